[hdl/interval_timer_three_channel_unit_defines.svh]
// Assertion macros for the interval timer unit.
// No dependencies; included by the top level.
`ifndef INTERVAL_TIMER_THREE_CHANNEL_UNIT_DEFINES_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ITU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ITU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ITU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/itu_pkg.sv]
// Package for the interval timer unit: codes, channel state type, BCD helper.
// No dependencies.
package itu_pkg;
    localparam int NUM_CHANNELS = 3;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_GATE  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [2:0] ADDR_CTRL = 3'd3;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] divider;
        logic [23:0] latched;
        logic [1:0]  latched_cnt;
        logic [1:0]  access;
        logic [2:0]  mode;
        logic [5:0]  status;
        logic        bcd;
        logic        high_next;
        logic        out;
        logic        last_out;
        logic        gate;
        logic        wait_div;
        logic        wait_gate;
    } chan_t;

    localparam chan_t CHAN_RESET = '{count: 16'h0, divider: 16'h0, latched: 24'h0,
        latched_cnt: 2'd0, access: 2'd0, mode: 3'd0, status: 6'd0, bcd: 1'b0,
        high_next: 1'b0, out: 1'b1, last_out: 1'b1, gate: 1'b1, wait_div: 1'b1,
        wait_gate: 1'b1};

    function automatic logic [2:0] eff_mode(input logic [2:0] m);
        eff_mode = (m >= 3'd6) ? (m - 3'd4) : m;
    endfunction

    function automatic logic [15:0] bcd_fix(input logic [15:0] v);
        logic [15:0] n;
        n = v;
        if (n[3:0] > 4'h9)   n = n - 16'h0006;
        if (n[7:4] > 4'h9)   n = n - 16'h0060;
        if (n[11:8] > 4'h9)  n = n - 16'h0600;
        if (n[15:12] > 4'h9) n = n - 16'h6000;
        bcd_fix = n;
    endfunction
endpackage

[hdl/itu_channel.sv]
// One timer channel: next-state logic for every action kind.
// Depends on itu_pkg.
module itu_channel (
    input  itu_pkg::chan_t   cur,
    input  logic             sel,
    input  logic [1:0]       action,
    input  logic             is_ctrl,
    input  logic [7:0]       write_data,
    input  logic             gate_level,
    output itu_pkg::chan_t   nxt,
    output logic [7:0]       rd_byte
);
    import itu_pkg::*;

    logic [2:0]  m;
    logic [15:0] n;
    logic [23:0] lv;
    logic [1:0]  lc;
    logic        do_latch;
    logic        no_count;
    logic        no_status;
    logic [7:0]  st;

    assign m = eff_mode(cur.mode);

    always_comb
    begin
        nxt = cur;
        rd_byte = 8'hff;
        n = 16'h0;
        lv = 24'h0;
        lc = 2'd0;
        do_latch = 1'b0;
        no_count = 1'b1;
        no_status = 1'b1;
        st = {cur.out, cur.wait_div, cur.status};
        if (action == ACT_WRITE && is_ctrl) begin
            if (write_data[7:6] == 2'b11) begin
                if (sel) begin
                    do_latch = 1'b1;
                    no_count = write_data[5];
                    no_status = write_data[4];
                end
            end else if (sel) begin
                if (write_data[5:4] == 2'b00) begin
                    do_latch = 1'b1;
                    no_count = 1'b0;
                end else begin
                    nxt.status = write_data[5:0];
                    nxt.access = write_data[5:4];
                    nxt.mode = write_data[3:1];
                    nxt.out = (write_data[3:1] != 3'd0);
                    nxt.wait_div = 1'b1;
                    nxt.wait_gate = 1'b0;
                    nxt.bcd = write_data[0];
                    nxt.high_next = 1'b0;
                end
            end
        end
        if (do_latch) begin
            if (!no_count) begin
                if (cur.access[1]) begin
                    lv = {16'h0, cur.count[15:8]};
                    lc = lc + 2'd1;
                end
                if (cur.access[0]) begin
                    lv = {lv[15:0], cur.count[7:0]};
                    lc = lc + 2'd1;
                end
            end
            if (!no_status) begin
                lv = {lv[15:0], st};
                lc = lc + 2'd1;
            end
            nxt.latched = lv;
            nxt.latched_cnt = lc;
        end
        if (sel && action == ACT_READ) begin
            if (cur.latched_cnt != 2'd0) begin
                rd_byte = cur.latched[7:0];
                nxt.latched_cnt = cur.latched_cnt - 2'd1;
                nxt.latched = {8'h0, cur.latched[23:8]};
            end else begin
                case (cur.access)
                    2'd1: begin rd_byte = cur.count[7:0]; nxt.high_next = 1'b0; end
                    2'd2: begin rd_byte = cur.count[15:8]; nxt.high_next = 1'b0; end
                    2'd3:
                    begin
                        rd_byte = cur.high_next ? cur.count[15:8] : cur.count[7:0];
                        nxt.high_next = ~cur.high_next;
                    end
                    default: rd_byte = 8'hff;
                endcase
            end
        end
        if (sel && action == ACT_WRITE && !is_ctrl) begin
            case (cur.access)
                2'd1:
                begin
                    nxt.divider = {cur.divider[15:8], write_data};
                    nxt.wait_div = 1'b0;
                    nxt.high_next = 1'b0;
                end
                2'd2:
                begin
                    nxt.divider = {write_data, cur.divider[7:0]};
                    nxt.wait_div = 1'b0;
                    nxt.high_next = 1'b0;
                end
                2'd3:
                begin
                    if (cur.high_next) begin
                        nxt.divider = {write_data, cur.divider[7:0]};
                        nxt.wait_div = 1'b0;
                    end else begin
                        nxt.divider = {cur.divider[15:8], write_data};
                        nxt.wait_div = 1'b1;
                    end
                    nxt.high_next = ~cur.high_next;
                end
                default: ;
            endcase
            if (!nxt.wait_div && (m == 3'd0 || m == 3'd4))
                nxt.count = nxt.divider;
        end
        if (sel && action == ACT_GATE) begin
            case (m)
                3'd1:
                    if (!cur.wait_div && !cur.gate && gate_level) begin
                        nxt.last_out = cur.out;
                        nxt.out = 1'b0;
                        nxt.count = cur.divider;
                    end
                3'd2, 3'd3:
                    if (!gate_level) begin
                        nxt.wait_gate = 1'b1;
                        if (m == 3'd2) begin
                            nxt.last_out = cur.out;
                            nxt.out = 1'b1;
                        end
                    end else if (!cur.gate) begin
                        nxt.count = cur.divider;
                        nxt.wait_gate = 1'b0;
                    end
                3'd4:
                    if (!gate_level) nxt.wait_div = 1'b1;
                3'd5:
                    if (!cur.gate && gate_level) begin
                        nxt.count = cur.divider;
                        nxt.wait_gate = 1'b0;
                    end
                default: ;
            endcase
            nxt.gate = gate_level;
        end
        if (sel && action == ACT_TICK && !cur.wait_div && !cur.wait_gate) begin
            n = cur.count - 16'd1;
            if (m == 3'd3 && n != 16'd0) n = n - 16'd1;
            if (cur.bcd) n = bcd_fix(n);
            nxt.count = n;
            if (n == 16'd0) begin
                case (m)
                    3'd0, 3'd1: begin nxt.last_out = cur.out; nxt.out = 1'b1; end
                    3'd2:
                    begin
                        nxt.last_out = 1'b0; nxt.out = 1'b1; nxt.count = cur.divider;
                    end
                    3'd3:
                    begin
                        nxt.last_out = cur.out; nxt.out = ~cur.out;
                        nxt.count = cur.divider;
                    end
                    3'd4: begin nxt.last_out = 1'b0; nxt.out = 1'b1; end
                    default: nxt.out = 1'b0;
                endcase
            end
        end
    end
endmodule

[hdl/interval_timer_three_channel_unit.sv]
// An input transfer is held in the input register, then its result in the result register.
// One item per cycle while out_ready holds; path: input register, channel logic, result register.
// All three channels update together in a single pass of combinational logic.
// Reset (rst_n low, async): channels return to idle, outputs high, no result held.
// Input stays ready while the result register is empty or being drained.
// Depends on itu_pkg, itu_channel and the defines header.
`include "interval_timer_three_channel_unit_defines.svh"
module interval_timer_three_channel_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [2:0] address,
    input  logic [7:0] write_data,
    input  logic [1:0] gate_channel,
    input  logic       gate_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       out_zero,
    output logic       out_one,
    output logic       out_two
);
    import itu_pkg::*;

    // input register
    logic       in_full_reg;
    logic [1:0] act_reg;
    logic [2:0] addr_reg;
    logic [7:0] data_reg;
    logic [1:0] gch_reg;
    logic       glv_reg;

    // channel state
    chan_t ch_reg [NUM_CHANNELS];
    chan_t ch_next [NUM_CHANNELS];
    logic [7:0] rd_ch [NUM_CHANNELS];

    // result register
    logic       out_full_reg;
    logic [7:0] rd_reg;

    logic stage_go;
    logic [7:0] rd_next;

    // Advance the input stage when the result slot is free or being drained.
    assign stage_go = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end else if (in_ready) begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            act_reg <= action;
            addr_reg <= address;
            data_reg <= write_data;
            gch_reg <= gate_channel;
            glv_reg <= gate_level;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_chan
            logic sel;
            // Control writes reach all channels; each decodes its own select.
            always_comb
            begin
                case (act_reg)
                    ACT_READ:  sel = (addr_reg == 3'(gi));
                    ACT_WRITE: sel = (addr_reg == ADDR_CTRL)
                        ? ((data_reg[7:6] == 2'(gi)) ||
                           (data_reg[7:6] == 2'b11 && data_reg[gi + 1]))
                        : (addr_reg == 3'(gi));
                    ACT_GATE:  sel = (gch_reg == 2'(gi));
                    default:   sel = 1'b1;
                endcase
            end

            itu_channel u_chan (
                .cur        (ch_reg[gi]),
                .sel        (sel),
                .action     (act_reg),
                .is_ctrl    (addr_reg == ADDR_CTRL),
                .write_data (data_reg),
                .gate_level (glv_reg),
                .nxt        (ch_next[gi]),
                .rd_byte    (rd_ch[gi])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    ch_reg[gi] <= CHAN_RESET;
                end else if (stage_go) begin
                    ch_reg[gi] <= ch_next[gi];
                end
            end
        end
    endgenerate

    // Select the read byte; non-reads return zero, unused addresses 255.
    always_comb
    begin
        rd_next = 8'h00;
        if (act_reg == ACT_READ) begin
            rd_next = 8'hff;
            for (int i = 0; i < NUM_CHANNELS; i++)
                if (addr_reg == 3'(i)) rd_next = rd_ch[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_full_reg <= 1'b0;
        end else if (stage_go) begin
            out_full_reg <= 1'b1;
        end else if (out_ready) begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go) rd_reg <= rd_next;
    end

    // Output levels track the channel state, which only moves with a new result.
    assign out_valid = out_full_reg;
    assign read_data = rd_reg;
    assign out_zero = ch_reg[0].out;
    assign out_one  = (NUM_CHANNELS > 1) ? ch_reg[NUM_CHANNELS > 1 ? 1 : 0].out : 1'b1;
    assign out_two  = (NUM_CHANNELS > 2) ? ch_reg[NUM_CHANNELS > 2 ? 2 : 0].out : 1'b1;

    `ITU_ASSERT_NEXT(a_stage_fills_out, clk, rst_n, stage_go, out_full_reg, "result lost")
    `ITU_ASSERT_IMPL(a_no_overrun, clk, rst_n, out_full_reg && !out_ready, !stage_go, "overrun")
    `ITU_ASSERT_NEXT(a_state_holds, clk, rst_n, !stage_go, $stable(out_zero), "out moved")
endmodule
